FILE: rtl/rnfa_pkg.sv
package rnfa_pkg;

    // Sizing
    localparam int MAX_SEATS    = 16;
    localparam int COUNT_W      = 16;
    localparam int SEAT_W       = $clog2(MAX_SEATS);
    localparam int NUM_W        = $clog2(MAX_SEATS + 1);
    localparam int SEAT_FIELD_W = 4;
    localparam int NUM_FIELD_W  = 5;
    localparam int SLACK_W      = 4;

    localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    // Operation codes
    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADD     = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_LAST_SEAT = 2'd1,
        STS_FULL      = 2'd2,
        STS_RANGE     = 2'd3
    } status_t;

    // Per-seat state
    typedef enum logic [1:0] {
        SS_IDLE   = 2'd0,
        SS_HUNGRY = 2'd1,
        SS_EATING = 2'd2
    } seat_state_t;

    // Which seat the current grant test looks at, relative to the target seat
    typedef enum logic [1:0] {
        TS_SELF  = 2'd0,
        TS_LEFT  = 2'd1,
        TS_RIGHT = 2'd2
    } test_sel_t;

    typedef struct packed {
        op_t                     operation;
        logic [SEAT_FIELD_W-1:0] seat;
    } rnfa_in_t;

    typedef struct packed {
        status_t                 status;
        logic                    grant_a_valid;
        logic [SEAT_FIELD_W-1:0] grant_a_seat;
        logic                    grant_b_valid;
        logic [SEAT_FIELD_W-1:0] grant_b_seat;
        logic [NUM_FIELD_W-1:0]  seat_count;
    } rnfa_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_in;
        logic      start;
        logic      do_add;
        logic      prep_write;
        logic      rd_nbrs;
        logic      rd_self;
        logic      eval;
        logic      commit;
        test_sel_t test_sel;
    } rnfa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic err;
        op_t  op;
        logic out_free;
    } rnfa_sts_t;

endpackage

FILE: rtl/rnfa_ctrl.sv
module rnfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rnfa_pkg::rnfa_sts_t sts,
    output rnfa_pkg::rnfa_cmd_t cmd
);
    import rnfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PREP,
        S_ADDR,
        S_HOLD,
        S_EVAL,
        S_FINISH
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    test_sel_t   tsel_reg, tsel_next;
    logic        in_ready_reg;

    assign in_ready = in_ready_reg;

    // Sequencing: one grant test is address, hold, evaluate
    always_comb
    begin
        state_next = state_reg;
        tsel_next  = tsel_reg;
        cmd        = '0;
        cmd.test_sel = tsel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.start = 1'b1;
                if (sts.err)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    case (sts.op)
                        OP_ADD:
                        begin
                            cmd.do_add = 1'b1;
                            state_next = S_FINISH;
                        end
                        OP_REQUEST:
                        begin
                            tsel_next  = TS_SELF;
                            state_next = S_PREP;
                        end
                        default:
                        begin
                            tsel_next  = TS_LEFT;
                            state_next = S_PREP;
                        end
                    endcase
                end
            end
            S_PREP:
            begin
                cmd.prep_write = 1'b1;
                state_next     = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.rd_nbrs = 1'b1;
                state_next  = S_HOLD;
            end
            S_HOLD:
            begin
                cmd.rd_self = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (tsel_reg == TS_LEFT)
                begin
                    tsel_next  = TS_RIGHT;
                    state_next = S_ADDR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tsel_reg     <= TS_SELF;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            tsel_reg     <= tsel_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

FILE: rtl/rnfa_datapath.sv
module rnfa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rnfa_pkg::rnfa_in_t            in_data,
    input  logic                          cfg_valid,
    input  logic [rnfa_pkg::SLACK_W-1:0]  cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output rnfa_pkg::rnfa_out_t           out_data,
    input  rnfa_pkg::rnfa_cmd_t           cmd,
    output rnfa_pkg::rnfa_sts_t           sts
);
    import rnfa_pkg::*;

    // Seat table
    seat_state_t        state_mem [MAX_SEATS];
    logic [COUNT_W-1:0] count_mem [MAX_SEATS];

    // Item and ring registers
    op_t                op_reg;
    logic [SEAT_W-1:0]  seat_reg;
    logic [SEAT_W-1:0]  tgt_reg;
    status_t            status_reg;
    logic [NUM_W-1:0]   active_reg;
    logic [COUNT_W-1:0] highest_reg;
    logic [SLACK_W-1:0] slack_reg;

    // Read data and held left neighbor
    seat_state_t        rd_a_state_reg, rd_b_state_reg, hold_l_state_reg;
    logic [COUNT_W-1:0] rd_a_count_reg, rd_b_count_reg, hold_l_count_reg;

    // Grant results of the current item
    logic               ga_reg, gb_reg;
    logic [SEAT_W-1:0]  sa_reg, sb_reg;

    rnfa_out_t          out_reg;
    logic               out_valid_reg;

    logic [SEAT_W-1:0]  last_seat;
    logic [SEAT_W-1:0]  tgt_l, tgt_r, test_seat, t_l, t_r;
    status_t            status_code;
    logic [SEAT_W-1:0]  addr_a;
    logic               rd_a_en, rd_b_en;
    logic               we_state, we_count;
    logic [SEAT_W-1:0]  wr_addr;
    seat_state_t        wr_state;
    logic [COUNT_W-1:0] wr_count;
    logic [COUNT_W:0]   lim_l, lim_r;
    logic               grant;
    logic [COUNT_W-1:0] c_inc;
    logic               remove_ok;
    logic [NUM_W-1:0]   active_after;

    function automatic logic [SEAT_W-1:0] left_of(input logic [SEAT_W-1:0] s,
                                                   input logic [SEAT_W-1:0] last);
        left_of = (s == '0) ? last : s - 1'b1;
    endfunction

    function automatic logic [SEAT_W-1:0] right_of(input logic [SEAT_W-1:0] s,
                                                    input logic [SEAT_W-1:0] last);
        right_of = (s == last) ? '0 : s + 1'b1;
    endfunction

    // Ring neighbors, wrapping at the current seat count
    assign last_seat = SEAT_W'(active_reg - 1'b1);
    assign tgt_l     = left_of(tgt_reg, last_seat);
    assign tgt_r     = right_of(tgt_reg, last_seat);

    always_comb
    begin
        case (cmd.test_sel)
            TS_LEFT:  test_seat = tgt_l;
            TS_RIGHT: test_seat = tgt_r;
            default:  test_seat = tgt_reg;
        endcase
    end

    assign t_l = left_of(test_seat, last_seat);
    assign t_r = right_of(test_seat, last_seat);

    // Operation check
    always_comb
    begin
        status_code = STS_OK;
        case (op_reg)
            OP_ADD:
            begin
                if (active_reg >= NUM_W'(MAX_SEATS))
                    status_code = STS_FULL;
            end
            OP_REMOVE:
            begin
                if (active_reg <= NUM_W'(1))
                    status_code = STS_LAST_SEAT;
            end
            default:
            begin
                if (NUM_W'(seat_reg) >= active_reg)
                    status_code = STS_RANGE;
            end
        endcase
    end

    assign sts.err      = (status_code != STS_OK);
    assign sts.op       = op_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    // Grant test: seat from port A, left held, right from port B
    assign lim_l = {1'b0, hold_l_count_reg} + (COUNT_W + 1)'(slack_reg);
    assign lim_r = {1'b0, rd_b_count_reg} + (COUNT_W + 1)'(slack_reg);
    assign grant = (rd_a_state_reg == SS_HUNGRY) &&
                   (hold_l_state_reg != SS_EATING) &&
                   (rd_b_state_reg != SS_EATING) &&
                   !({1'b0, rd_a_count_reg} > lim_l) &&
                   !({1'b0, rd_a_count_reg} > lim_r);
    assign c_inc = (rd_a_count_reg == COUNT_MAX) ? rd_a_count_reg : rd_a_count_reg + 1'b1;

    // Read ports
    assign addr_a  = cmd.rd_nbrs ? t_l : test_seat;
    assign rd_a_en = cmd.rd_nbrs || cmd.rd_self;
    assign rd_b_en = cmd.rd_nbrs;

    // Write port
    always_comb
    begin
        we_state = 1'b0;
        we_count = 1'b0;
        wr_addr  = test_seat;
        wr_state = SS_EATING;
        wr_count = c_inc;
        if (cmd.do_add)
        begin
            we_state = 1'b1;
            we_count = 1'b1;
            wr_addr  = SEAT_W'(active_reg);
            wr_state = SS_IDLE;
            wr_count = highest_reg;
        end
        else if (cmd.prep_write)
        begin
            we_state = 1'b1;
            wr_addr  = tgt_reg;
            wr_state = (op_reg == OP_REQUEST) ? SS_HUNGRY : SS_IDLE;
        end
        else if (cmd.eval && grant)
        begin
            we_state = 1'b1;
            we_count = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_state)
            state_mem[wr_addr] <= wr_state;
        if (we_count)
            count_mem[wr_addr] <= wr_count;
        if (rd_a_en)
        begin
            rd_a_state_reg <= state_mem[addr_a];
            rd_a_count_reg <= count_mem[addr_a];
        end
        if (rd_b_en)
        begin
            rd_b_state_reg <= state_mem[t_r];
            rd_b_count_reg <= count_mem[t_r];
        end
    end

    // Item payload, left neighbor hold and grant record
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= in_data.operation;
            seat_reg <= SEAT_W'(in_data.seat);
        end
        if (cmd.start)
        begin
            status_reg <= status_code;
            tgt_reg    <= (op_reg == OP_REMOVE) ? last_seat : seat_reg;
            ga_reg     <= 1'b0;
            gb_reg     <= 1'b0;
            sa_reg     <= '0;
            sb_reg     <= '0;
        end
        if (cmd.rd_self)
        begin
            hold_l_state_reg <= rd_a_state_reg;
            hold_l_count_reg <= rd_a_count_reg;
        end
        if (cmd.eval && grant)
        begin
            if (cmd.test_sel == TS_RIGHT)
            begin
                gb_reg <= 1'b1;
                sb_reg <= test_seat;
            end
            else
            begin
                ga_reg <= 1'b1;
                sa_reg <= test_seat;
            end
        end
        if (cmd.commit)
        begin
            out_reg.status        <= status_reg;
            out_reg.grant_a_valid <= ga_reg;
            out_reg.grant_a_seat  <= SEAT_FIELD_W'(sa_reg);
            out_reg.grant_b_valid <= gb_reg;
            out_reg.grant_b_seat  <= SEAT_FIELD_W'(sb_reg);
            out_reg.seat_count    <= NUM_FIELD_W'(active_after);
        end
    end

    assign remove_ok    = (op_reg == OP_REMOVE) && (status_reg == STS_OK);
    assign active_after = remove_ok ? active_reg - 1'b1 : active_reg;

    // Ring state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            highest_reg   <= '0;
            slack_reg     <= SLACK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                slack_reg <= cfg_data;
            if (cmd.do_add)
                active_reg <= active_reg + 1'b1;
            else if (cmd.commit)
                active_reg <= active_after;
            if (cmd.eval && grant && (c_inc > highest_reg))
                highest_reg <= c_inc;
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/ring_neighbor_fork_arbiter.sv
// From input transfer to result valid, add and any refused operation pass
// dispatch only; request also writes the target seat and tests it, while
// release and remove write it and test the left and then the right neighbor,
// a pass set by the seat table's two registered read ports. One item at a time;
// the next input is taken after the result is loaded, and a stalled output holds it.
// Reset (rst_n low, asynchronous) empties the ring and sets slack to 2.
module ring_neighbor_fork_arbiter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rnfa_pkg::rnfa_in_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rnfa_pkg::rnfa_out_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rnfa_pkg::SLACK_W-1:0] cfg_data
);
    import rnfa_pkg::*;

    rnfa_cmd_t cmd;
    rnfa_sts_t sts;

    // Slack register takes a write in any cycle
    assign cfg_ready = 1'b1;

    rnfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rnfa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: rtl/rnfa_checker.sv
module rnfa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input rnfa_pkg::rnfa_in_t           in_data,
    input logic                         out_valid,
    input logic                         out_ready,
    input rnfa_pkg::rnfa_out_t          out_data,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [rnfa_pkg::SLACK_W-1:0] cfg_data
);
    import rnfa_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One item in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // Grant seat fields are zero when their valid bit is clear
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.grant_a_valid || out_data.grant_a_seat == '0) &&
                      (out_data.grant_b_valid || out_data.grant_b_seat == '0))
        else $error("grant seat set without grant");

    // A refused operation grants nothing
    a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STS_OK |->
            !out_data.grant_a_valid && !out_data.grant_b_valid)
        else $error("grant on refused operation");

    // Seat count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.seat_count <= NUM_FIELD_W'(MAX_SEATS))
        else $error("seat count beyond table size");

endmodule

bind ring_neighbor_fork_arbiter rnfa_checker u_rnfa_checker (.*);
